// ===== sv/shabh_pkg.sv =====
package shabh_pkg;

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } q_entry_t;

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t big_sig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== sv/shabh_ifs.sv =====
interface shabh_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface shabh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ===== sv/shabh_front.sv =====
module shabh_front (
  input  logic                clk,
  input  logic                rst_n,
  shabh_in_if.sink            in_ch,
  output logic                q_valid,
  output shabh_pkg::q_entry_t q_head,
  input  logic                q_pop
);
  import shabh_pkg::*;

  q_entry_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]         count_r;
  logic                    push, pop;

  assign in_ch.ready = (count_r != (QPTR_W+1)'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && q_valid;
  assign q_valid     = (count_r != '0);
  assign q_head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{cmd: in_ch.cmd, data_byte: in_ch.data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

// ===== sv/shabh_core.sv =====
module shabh_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  shabh_pkg::q_entry_t q_head,
  output logic                q_pop,
  shabh_out_if.source         out_ch
);
  import shabh_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PADZ = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_COMP = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]   state_r, state_nxt, ret_r, ret_nxt;
  logic [6:0]   round_r, round_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [2:0]   len_r, len_nxt;
  logic [2:0]   sel_r, sel_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic [511:0] win_r, win_nxt;
  word_t        hash_r [8];
  word_t        hash_nxt [8];
  word_t        vars_r [8];
  word_t        vars_nxt [8];
  logic         ov_r, ov_nxt;
  word_t        ow_r, ow_nxt;
  logic [2:0]   oi_r, oi_nxt;
  logic         ol_r, ol_nxt;

  logic         push_en, go_comp;
  logic [7:0]   push_byte;
  logic [2:0]   lsel;
  word_t        w0, w1, w9, w14, w_new, wt, t1, t2;
  word_t        ea, eb, ec, ee, ef, eg;

  // window word 0 is the oldest schedule word
  assign w0  = win_r[511:480];
  assign w1  = win_r[479:448];
  assign w9  = win_r[223:192];
  assign w14 = win_r[63:32];
  assign w_new = small_sig1(w14) + w9 + small_sig0(w1) + w0;
  assign wt    = (round_r < 7'd16) ? w0 : w_new;

  assign ea = vars_r[0];
  assign eb = vars_r[1];
  assign ec = vars_r[2];
  assign ee = vars_r[4];
  assign ef = vars_r[5];
  assign eg = vars_r[6];
  assign t1 = vars_r[7] + big_sig1(ee) + ((ee & ef) ^ (~ee & eg)) + K_TAB[round_r[5:0]] + wt;
  assign t2 = big_sig0(ea) + ((ea & eb) ^ (ea & ec) ^ (eb & ec));

  assign lsel = 3'(3'd7 - len_r);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    round_nxt = round_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    sel_nxt   = sel_r;
    bits_nxt  = bits_r;
    win_nxt   = win_r;
    hash_nxt  = hash_r;
    vars_nxt  = vars_r;
    ov_nxt    = ov_r && !out_ch.ready;
    ow_nxt    = ow_r;
    oi_nxt    = oi_r;
    ol_nxt    = ol_r;
    q_pop     = 1'b0;
    push_en   = 1'b0;
    push_byte = 8'h00;
    go_comp   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          push_en = 1'b1;
          if (q_head.cmd == CMD_DATA) begin
            push_byte = q_head.data_byte;
            bits_nxt  = bits_r + 64'd8;
            if (fill_r == 6'd63) begin
              go_comp = 1'b1;
              ret_nxt = S_IDLE;
            end
          end else begin
            push_byte = 8'h80;
            if (fill_r == 6'd63) begin
              go_comp = 1'b1;
              ret_nxt = S_PADZ;
            end else if (fill_r == 6'd55) begin
              state_nxt = S_LEN;
              len_nxt   = '0;
            end else begin
              state_nxt = S_PADZ;
            end
          end
        end
      end
      S_PADZ: begin
        push_en = 1'b1;
        if (fill_r == 6'd63) begin
          go_comp = 1'b1;
          ret_nxt = S_PADZ;
        end else if (fill_r == 6'd55) begin
          state_nxt = S_LEN;
          len_nxt   = '0;
        end
      end
      S_LEN: begin
        push_en   = 1'b1;
        push_byte = bits_r[{lsel, 3'b000} +: 8];
        len_nxt   = len_r + 1'b1;
        if (len_r == 3'd7) begin
          go_comp = 1'b1;
          ret_nxt = S_OUT;
          sel_nxt = '0;
        end
      end
      S_COMP: begin
        if (!round_r[6]) begin
          win_nxt     = {win_r[479:0], wt};
          vars_nxt[7] = vars_r[6];
          vars_nxt[6] = vars_r[5];
          vars_nxt[5] = vars_r[4];
          vars_nxt[4] = vars_r[3] + t1;
          vars_nxt[3] = vars_r[2];
          vars_nxt[2] = vars_r[1];
          vars_nxt[1] = vars_r[0];
          vars_nxt[0] = t1 + t2;
          round_nxt   = round_r + 1'b1;
        end else begin
          for (int j = 0; j < 8; j++) begin
            hash_nxt[j] = hash_r[j] + vars_r[j];
          end
          state_nxt = ret_r;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          ow_nxt = hash_r[sel_r];
          oi_nxt = sel_r;
          ol_nxt = (sel_r == 3'd7);
          sel_nxt = sel_r + 1'b1;
          if (sel_r == 3'd7) begin
            hash_nxt  = INIT_H;
            bits_nxt  = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (push_en) begin
      win_nxt  = {win_r[503:0], push_byte};
      fill_nxt = fill_r + 1'b1;
    end
    if (go_comp) begin
      state_nxt = S_COMP;
      round_nxt = '0;
      vars_nxt  = hash_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      round_r <= '0;
      fill_r  <= '0;
      len_r   <= '0;
      sel_r   <= '0;
      bits_r  <= '0;
      hash_r  <= INIT_H;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      round_r <= round_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      sel_r   <= sel_nxt;
      bits_r  <= bits_nxt;
      hash_r  <= hash_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    vars_r <= vars_nxt;
    ow_r   <= ow_nxt;
    oi_r   <= oi_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.digest_word = ow_r;
  assign out_ch.word_index  = oi_r;
  assign out_ch.last_word   = ol_r;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("queue pop outside idle");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMP |-> round_r <= 7'd64) else $error("round counter overrun");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ol_r |-> oi_r == 3'd7) else $error("last flag on wrong word");
  a_len_fill: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LEN |-> fill_r[5:3] == 3'b111) else $error("length bytes misplaced");
`endif

endmodule

// ===== sv/sha256_byte_stream_hasher_unit.sv =====
// channel  | dir | payload                              | transfer
// in_ch    | in  | cmd, data_byte                       | valid && ready
// out_ch   | out | digest_word, word_index, last_word   | valid && ready
// A data byte is taken from the queue by the back end; every 64th byte starts a
// compression (one round per cycle, then the hash update) that holds off the queue.
// Finish: pad and length bytes go in one per cycle up to the block end, each padded
// block is compressed (two blocks when more than 55 bytes are held), then 8 output words.
// A 4-deep input queue keeps in_ch accepting while the back end works or out_ch stalls.
// Synchronous active-low reset restores the initial hash and clears the counts.
module sha256_byte_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  shabh_in_if.sink    in_ch,
  shabh_out_if.source out_ch
);
  import shabh_pkg::*;

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;

  shabh_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  shabh_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import shabh_pkg::*;

  typedef struct {
    word_t      digest;
    logic [2:0] idx;
    logic       last;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  shabh_in_if  in_ch ();
  shabh_out_if out_ch ();

  sha256_byte_stream_hasher_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // predictor state
  word_t      hv [8];
  logic [7:0] blk [64];
  int         fill;
  logic [63:0] msg_bits;

  q_entry_t     pending [$];
  digest_word_t digest_q [$];
  int           errors = 0;
  int           cycle = 0;
  int           hold_left = 0;
  logic         took = 1'b0;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    word_t w [16];
    word_t v [8];
    word_t wt, t1, t2, a15, a2;
    for (int j = 0; j < 8; j++) v[j] = hv[j];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      end else begin
        a15 = w[(t - 15) & 15];
        a2  = w[(t - 2) & 15];
        wt = w[t & 15] + (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3)) + w[(t - 7) & 15]
             + (rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10));
      end
      w[t & 15] = wt;
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hv[j] += v[j];
  endtask

  task automatic hash_reset();
    for (int j = 0; j < 8; j++) hv[j] = IV[j];
    fill = 0;
    msg_bits = '0;
  endtask

  task automatic absorb_or_finish(q_entry_t e);
    digest_word_t d;
    if (e.cmd == CMD_DATA) begin
      blk[fill] = e.data_byte;
      msg_bits += 64'd8;
      fill++;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end else begin
      blk[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        for (int i = fill; i < 64; i++) blk[i] = 8'h00;
        compress_block();
        fill = 0;
      end
      for (int i = fill; i < 56; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56 + i] = msg_bits[63 - 8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        d.digest = hv[i];
        d.idx = 3'(i);
        d.last = (i == 7);
        digest_q.push_back(d);
      end
      hash_reset();
    end
  endtask

  task automatic add_item(logic c, logic [7:0] b);
    q_entry_t e;
    e.cmd = c;
    e.data_byte = b;
    pending.push_back(e);
  endtask

  task automatic add_message(int len);
    for (int i = 0; i < len; i++) add_item(CMD_DATA, 8'($urandom));
    add_item(CMD_FINISH, 8'($urandom));
  endtask

  function automatic bit no_idle_window();
    return cycle >= 1500 && cycle < 2500;
  endfunction

  // sender: a new transaction is offered once the previous one was taken
  always @(posedge clk) begin
    took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready)
      absorb_or_finish('{cmd: in_ch.cmd, data_byte: in_ch.data_byte});
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || took) begin
      if (pending.size() > 0 && (no_idle_window() || $urandom_range(0, 99) >= 28)) begin
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= pending[0].cmd;
        in_ch.data_byte <= pending[0].data_byte;
        void'(pending.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (cycle == 600) begin
      out_ch.ready <= 1'b0;
      hold_left <= 400;
    end else begin
      out_ch.ready <= no_idle_window() || $urandom_range(0, 99) >= 28;
    end
  end

  always @(posedge clk) begin
    digest_word_t d;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected digest transaction: word %h idx %0d last %b",
                   out_ch.digest_word, out_ch.word_index, out_ch.last_word);
      end else begin
        d = digest_q.pop_front();
        if (out_ch.digest_word !== d.digest || out_ch.word_index !== d.idx ||
            out_ch.last_word !== d.last) begin
          errors++;
          if (errors <= 10)
            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                     d.digest, d.idx, d.last,
                     out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 300000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int n, r, mlen;
    int lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_DATA;
    in_ch.data_byte = 8'h00;
    out_ch.ready = 1'b0;
    hash_reset();

    // directed: empty message (data ignored), "abc", extreme byte values
    add_item(CMD_FINISH, 8'hff);
    add_item(CMD_DATA, 8'h61);
    add_item(CMD_DATA, 8'h62);
    add_item(CMD_DATA, 8'h63);
    add_item(CMD_FINISH, 8'h00);
    add_item(CMD_DATA, 8'h00);
    add_item(CMD_DATA, 8'hff);
    add_item(CMD_DATA, 8'h55);
    add_item(CMD_DATA, 8'haa);
    add_item(CMD_FINISH, 8'h5a);
    add_item(CMD_FINISH, 8'ha5);

    // random messages, some sized around the padding boundaries
    n = pending.size();
    while (n < 180) begin
      r = $urandom_range(0, 9);
      if (r < 2) mlen = lens[$urandom_range(0, 7)];
      else mlen = $urandom_range(0, 20);
      // keep the total item count near its target
      if (mlen > 179 - n) mlen = 179 - n;
      add_message(mlen);
      n = pending.size();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() > 0 || in_ch.valid || digest_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/shabh_pkg.sv
sv/shabh_ifs.sv
sv/shabh_front.sv
sv/shabh_core.sv
sv/sha256_byte_stream_hasher_unit.sv
tb/tb.sv
